/* hdl/smallest_word_tracker_defines.svh */
// Assertion shorthands for the smallest word tracker.
// Both sample on clk and are off while rst_n is low.
`ifndef SMALLEST_WORD_TRACKER_DEFINES_SVH
`define SMALLEST_WORD_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define SWT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smallest_word_tracker: check failed");

// Next-cycle implication.
`define SWT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smallest_word_tracker: check failed");

`endif

/* hdl/swt_pkg.sv */
package swt_pkg;

    // Longest word kept; longer words are cut to this many bytes.
    localparam int MAX_WORD = 32;
    localparam int DEPTH    = 2 * MAX_WORD;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam logic [1:0] VERDICT_EQUAL   = 2'd0;
    localparam logic [1:0] VERDICT_LESS    = 2'd1;
    localparam logic [1:0] VERDICT_GREATER = 2'd2;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUESTION = 8'h3F;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [7:0] word_byte;
        logic       word_last;
        logic       no_word;
        logic       truncated;
    } out_word_t;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] length;
        logic             valid;
        logic             cut;
    } best_info_t;

    typedef struct packed {
        logic       start;
        best_info_t best;
    } emit_req_t;

    function automatic logic is_divider(logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_PERIOD, CH_QUESTION,
                         CH_BANG, CH_DQUOTE, CH_SEMI, CH_SQUOTE, CH_COMMA};
    endfunction

    // Bank 0 holds entries 0..MAX_WORD-1, bank 1 the rest.
    function automatic logic [ADDR_W-1:0] mem_addr(logic bank, logic [LEN_W-1:0] pos);
        return ({ADDR_W{bank}} & ADDR_W'(MAX_WORD)) + ADDR_W'(pos);
    endfunction

endpackage

/* hdl/swt_ram.sv */
module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/swt_scan.sv */
module swt_scan import swt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  in_word_t          text,
    input  logic [7:0]        rd_data,
    output logic              we,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic [ADDR_W-1:0] rd_addr,
    output emit_req_t         emit_req,
    output logic              hold
);

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] best_len;
        logic             best_valid;
        logic             best_cut;
        logic [LEN_W-1:0] cur_len;
        logic             cur_cut;
        logic             in_word;
        logic [1:0]       verdict;
    } track_t;

    function automatic track_t track_clear();
        track_t r;
        r = '0;
        r.verdict = VERDICT_EQUAL;
        return r;
    endfunction

    function automatic track_t close_word(track_t t);
        track_t r;
        logic   take;
        r = t;
        take = 1'b0;
        if (t.in_word)
        begin
            if (!t.best_valid || t.verdict == VERDICT_LESS)
            begin
                take = 1'b1;
            end
            else if (t.verdict == VERDICT_EQUAL)
            begin
                if (t.cur_len < t.best_len)
                begin
                    take = 1'b1;
                end
                else if (t.cur_len == t.best_len && !t.cur_cut && t.best_cut)
                begin
                    take = 1'b1;
                end
            end
            if (take)
            begin
                r.bank       = ~t.bank;
                r.best_len   = t.cur_len;
                r.best_cut   = t.cur_cut;
                r.best_valid = 1'b1;
            end
            r.in_word = 1'b0;
            r.cur_len = '0;
            r.cur_cut = 1'b0;
            r.verdict = VERDICT_EQUAL;
        end
        return r;
    endfunction

    function automatic track_t take_byte(track_t t, logic [7:0] b, logic [7:0] ref_byte);
        track_t r;
        r = t;
        if (!t.in_word)
        begin
            r.in_word = 1'b1;
            r.cur_len = '0;
            r.cur_cut = 1'b0;
            r.verdict = VERDICT_EQUAL;
        end
        if (r.cur_len < LEN_W'(MAX_WORD))
        begin
            if (r.best_valid && r.verdict == VERDICT_EQUAL)
            begin
                if (r.cur_len >= r.best_len)
                begin
                    r.verdict = VERDICT_GREATER;
                end
                else if (b < ref_byte)
                begin
                    r.verdict = VERDICT_LESS;
                end
                else if (b > ref_byte)
                begin
                    r.verdict = VERDICT_GREATER;
                end
            end
            r.cur_len = LEN_W'(r.cur_len + LEN_W'(1));
        end
        else
        begin
            // cut word: if still equal so far, it loses; against an equally cut best it ties and the best is kept
            r.cur_cut = 1'b1;
            if (r.best_valid && r.verdict == VERDICT_EQUAL &&
                (r.best_len < LEN_W'(MAX_WORD) || !r.best_cut))
            begin
                r.verdict = VERDICT_GREATER;
            end
        end
        return r;
    endfunction

    logic             s1_valid_reg;
    in_word_t         s1_word_reg;
    track_t           track_reg;
    track_t           track_next;
    logic [LEN_W-1:0] pos;
    logic             pos_in_store;

    // Stage 1: the word accepted last cycle meets the store byte read for it.
    always_comb
    begin
        track_next = track_reg;
        emit_req   = '0;
        if (s1_valid_reg)
        begin
            if (is_divider(s1_word_reg.text_byte))
            begin
                track_next = close_word(track_next);
            end
            else
            begin
                track_next = take_byte(track_next, s1_word_reg.text_byte, rd_data);
            end
            if (s1_word_reg.end_of_text)
            begin
                track_next          = close_word(track_next);
                emit_req.start      = 1'b1;
                emit_req.best.bank  = track_next.bank;
                emit_req.best.length = track_next.best_len;
                emit_req.best.valid = track_next.best_valid;
                emit_req.best.cut   = track_next.best_cut;
                track_next          = track_clear();
            end
        end
    end

    // Stage 0: addresses come from the state after stage 1, so no bubble.
    assign pos          = track_next.in_word ? track_next.cur_len : '0;
    assign pos_in_store = pos < LEN_W'(MAX_WORD);
    assign we           = accept && !is_divider(text.text_byte) && pos_in_store;
    assign wr_addr      = mem_addr(~track_next.bank, pos);
    assign wr_data      = text.text_byte;
    assign rd_addr      = mem_addr(track_next.bank, pos_in_store ? pos : '0);
    assign hold         = s1_valid_reg && s1_word_reg.end_of_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            track_reg    <= track_clear();
        end
        else
        begin
            s1_valid_reg <= accept;
            track_reg    <= track_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= text;
        end
    end

endmodule

/* hdl/swt_emit.sv */
module swt_emit import swt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  emit_req_t         emit_req,
    input  logic [7:0]        rd_data,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              busy,
    output logic              result_valid,
    input  logic              result_stall,
    output out_word_t         result
);

    logic             busy_reg;
    logic [LEN_W-1:0] k_reg;
    best_info_t       info_reg;
    logic             infl_reg;
    logic             infl_last_reg;
    logic             infl_empty_reg;
    out_word_t        fifo_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    logic       pop;
    logic       issue;
    logic       issue_last;
    logic       empty_case;
    logic [1:0] occ;
    out_word_t  entry;

    assign pop        = (count_reg != 2'd0) && !result_stall;
    assign occ        = count_reg + {1'b0, infl_reg} - {1'b0, pop};
    // two slots: one read in flight plus what is queued must fit
    assign issue      = busy_reg && (occ < 2'd2);
    assign empty_case = !info_reg.valid || (info_reg.length == '0);
    assign issue_last = empty_case || (LEN_W'(k_reg + LEN_W'(1)) == info_reg.length);
    assign rd_addr    = mem_addr(info_reg.bank, k_reg);
    assign busy       = busy_reg;

    always_comb
    begin
        entry.word_byte = infl_empty_reg ? 8'h00 : rd_data;
        entry.word_last = infl_last_reg;
        entry.no_word   = infl_empty_reg;
        entry.truncated = infl_empty_reg ? 1'b0 : info_reg.cut;
    end

    assign result_valid = count_reg != 2'd0;
    assign result       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            k_reg      <= '0;
            infl_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (emit_req.start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (issue)
            begin
                k_reg <= LEN_W'(k_reg + LEN_W'(1));
                if (issue_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            infl_reg <= issue;
            if (infl_reg)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, infl_reg} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_req.start)
        begin
            info_reg <= emit_req.best;
        end
        infl_last_reg  <= issue_last;
        infl_empty_reg <= empty_case;
        if (infl_reg)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

/* hdl/smallest_word_tracker.sv */
// Smallest word tracker.
// Text channel: text_valid / text_stall / text carry one byte per word, with
// end_of_text on the final byte. Bytes are taken one per cycle while text_stall is low,
// each compared in the cycle after it is taken. Each costs one read of the best-word
// bank and, if a kept word byte, one write into the other bank of a single 64-entry store.
// Result channel: result_valid / result_stall / result carry the smallest word,
// one byte per word, word_last on the last; an empty text gives one word with
// no_word set. truncated marks a word that was cut to MAX_WORD bytes.
// A taken end_of_text reaches scan stage 1, which starts the output run; each store
// read of the run fills the output queue, which offers results one per cycle while
// result_stall is low. The store read port serves the output run, so text_stall is
// high from the cycle after end_of_text until the last byte of the run has been read.
// A 2-word output queue holds results while result_stall is high; reads pause
// until it has room, and nothing is dropped.
// Reset clears all tracking; the store is not cleared, since only bytes of the
// best word, always written before, are ever used from it.
`include "smallest_word_tracker_defines.svh"

module smallest_word_tracker import swt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      text_valid,
    output logic      text_stall,
    input  in_word_t  text,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    logic              text_accept;
    logic              scan_hold;
    logic              emit_busy;
    emit_req_t         emit_req;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [ADDR_W-1:0] scan_rd_addr;
    logic [ADDR_W-1:0] emit_rd_addr;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    assign text_stall  = scan_hold || emit_busy;
    assign text_accept = text_valid && !text_stall;
    assign ram_rd_addr = emit_busy ? emit_rd_addr : scan_rd_addr;

    swt_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    swt_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (text_accept),
        .text     (text),
        .rd_data  (ram_rd_data),
        .we       (ram_we),
        .wr_addr  (ram_wr_addr),
        .wr_data  (ram_wr_data),
        .rd_addr  (scan_rd_addr),
        .emit_req (emit_req),
        .hold     (scan_hold)
    );

    swt_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit_req     (emit_req),
        .rd_data      (ram_rd_data),
        .rd_addr      (emit_rd_addr),
        .busy         (emit_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // writes go to the other bank than the compare read
    `SWT_ASSERT_IMP(a_bank_split, ram_we, ram_wr_addr != ram_rd_addr)
    // the output run owns the read port
    `SWT_ASSERT_IMP(a_no_write_in_run, emit_busy, !ram_we)
    // end of text starts a run in the next cycle
    `SWT_ASSERT_NXT(a_end_starts_run, text_accept && text.end_of_text, emit_req.start)
    `SWT_ASSERT_IMP(a_empty_is_last, result_valid && result.no_word, result.word_last)

endmodule
